// File: hdl/xzrd_pkg.sv
// Shared constants and types for the XOR delta / zero-run encoder.
// No dependencies; used by xzrd_plan, xor_zero_run_delta_encoder and xzrd_stream_checker.
`default_nettype none

package xzrd_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned COUNT_W         = 17;
    localparam int unsigned RUN_W           = 8;
    localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned LIMIT_RAW   = (64'(MAX_FRAME_BYTES) * 64'd3) / 64'd2;
    localparam logic [COUNT_W-1:0] ENCODED_LIMIT =
        (LIMIT_RAW < COUNT_MAX) ? COUNT_W'(LIMIT_RAW) : COUNT_W'(COUNT_MAX);

    localparam logic [7:0] ESCAPE_BYTE = 8'h00;

    // per-item emit plan: result count, byte at the current slot, run left behind
    typedef struct packed {
        logic [1:0]       n_res;
        logic [7:0]       byte_val;
        logic [RUN_W-1:0] run_after;
    } plan_t;

endpackage

`default_nettype wire

// File: hdl/xor_zero_run_delta_encoder.sv
// Top level of the XOR delta encoder with zero-run escapes.
// Depends on xzrd_pkg and xzrd_plan.
//
// channel | dir | tdata                                      | tlast      | tuser
// s_      | in  | [7:0] base_byte, [15:8] cur_byte            | frame_last | -
// m_      | out | [7:0] out_byte, [8] item_last, [25:9] count | frame_end  | -
//
// One input register feeds one output register. Wordless items stream at
// one per cycle even under an output stall, one-word items at one per cycle
// while the output is free; a two- or three-word item holds the input
// register until its last word enters the output register. Reset clears the
// run and byte counters and both valid flags. Output stalls back up into s_tready.
`default_nettype none

module xor_zero_run_delta_encoder
    import xzrd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] base_byte, [15:8] cur_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [8] item_last, [25:9] encoded_count
    output logic             m_tlast
);

    logic               in_valid_reg;
    logic [7:0]         in_x_reg;
    logic               in_last_reg;
    logic [1:0]         idx_reg,  idx_next;
    logic [RUN_W-1:0]   run_reg,  run_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;

    logic               m_valid_reg;
    logic [7:0]         m_byte_reg;
    logic               m_item_last_reg;
    logic               m_frame_end_reg;
    logic [COUNT_W-1:0] m_count_reg;

    plan_t              plan;
    logic               out_free;
    logic               final_slot;
    logic               emit;
    logic               item_done;
    logic [COUNT_W-1:0] count_inc;

    xzrd_plan u_plan (
        .x_val      (in_x_reg),
        .frame_last (in_last_reg),
        .run_count  (run_reg),
        .slot       (idx_reg),
        .plan       (plan)
    );

    always_comb begin
        out_free   = !m_valid_reg || m_tready;
        final_slot = (idx_reg == plan.n_res - 2'd1);
        emit       = in_valid_reg && (plan.n_res != 2'd0) && out_free;
        item_done  = in_valid_reg && ((plan.n_res == 2'd0) || (out_free && final_slot));
        s_tready   = !in_valid_reg || item_done;

        count_inc = (emitted_reg < ENCODED_LIMIT) ? emitted_reg + COUNT_W'(1) : emitted_reg;

        idx_next = idx_reg;
        if (item_done) begin
            idx_next = 2'd0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end

        run_next     = item_done ? plan.run_after : run_reg;
        emitted_next = emit ? count_inc : emitted_reg;
        if (item_done && in_last_reg) begin
            emitted_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= 2'd0;
            run_reg      <= '0;
            emitted_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            emitted_reg <= emitted_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_x_reg    <= s_tdata[7:0] ^ s_tdata[15:8];
            in_last_reg <= s_tlast;
        end
        if (emit) begin
            m_byte_reg      <= plan.byte_val;
            m_item_last_reg <= final_slot;
            m_frame_end_reg <= final_slot && in_last_reg;
            m_count_reg     <= count_inc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_item_last_reg, m_byte_reg};
    assign m_tlast  = m_frame_end_reg;

    a_frame_end_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_frame_end_reg |-> m_item_last_reg)
        else $error("frame end without item end");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_count_reg != '0)
        else $error("encoded count zero on a valid word");

    a_frame_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        item_done && in_last_reg |=> run_reg == '0 && emitted_reg == '0)
        else $error("state not cleared after frame end");

    a_idle_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> idx_reg == 2'd0)
        else $error("slot index nonzero with no held item");

endmodule

`default_nettype wire

// File: hdl/xzrd_plan.sv
// Per-item result planner: counts the words one held item produces, picks
// the byte for a given slot and gives the run left behind. Depends on xzrd_pkg.
`default_nettype none

module xzrd_plan
    import xzrd_pkg::*;
(
    input  wire logic [7:0]       x_val,
    input  wire logic             frame_last,
    input  wire logic [RUN_W-1:0] run_count,
    input  wire logic [1:0]       slot,
    output plan_t                 plan
);

    logic zero_x;
    logic run_full;
    logic run_pending;

    always_comb begin
        zero_x      = (x_val == 8'h00);
        run_full    = (run_count == {RUN_W{1'b1}});
        run_pending = (run_count != '0);

        plan.run_after = '0;
        plan.byte_val  = x_val;
        plan.n_res     = 2'd1;

        if (zero_x) begin
            if (run_full || frame_last) begin
                plan.n_res = 2'd2;
                plan.byte_val = (slot == 2'd0) ? ESCAPE_BYTE : run_count;
            end else begin
                plan.n_res     = 2'd0;
                plan.run_after = run_count + RUN_W'(1);
            end
        end else if (run_pending) begin
            plan.n_res = 2'd3;
            case (slot)
                2'd0:    plan.byte_val = ESCAPE_BYTE;
                2'd1:    plan.byte_val = run_count - RUN_W'(1);
                default: plan.byte_val = x_val;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: verif/xzrd_stream_checker.sv
// Stream checker for xor_zero_run_delta_encoder: predicts the encoded words from the
// accepted input words and compares them with the m_ channel. Depends on xzrd_pkg.
module xzrd_stream_checker
    import xzrd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] base_byte, [15:8] cur_byte
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [7:0] out_byte, [8] item_last, [25:9] encoded_count
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_CHUNK = 256;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               item_last;
        logic               frame_end;
        logic [COUNT_W-1:0] enc_count;
    } enc_word_t;

    enc_word_t          encoded_q[$];
    enc_word_t          step_words[0:2];
    int                 step_n;
    logic [8:0]         run_len;
    logic [COUNT_W-1:0] frame_bytes;
    enc_word_t          exp_w;

    task automatic put_encoded(input logic [7:0] value);
        if (frame_bytes < ENCODED_LIMIT)
            frame_bytes = frame_bytes + COUNT_W'(1);
        step_words[step_n] = '{value, 1'b0, 1'b0, frame_bytes};
        step_n++;
    endtask

    task automatic put_run();
        put_encoded(ESCAPE_BYTE);
        put_encoded(8'(run_len - 9'd1));
        run_len = '0;
    endtask

    task automatic encode_pair(input logic [7:0] base_b, input logic [7:0] cur_b,
                               input logic last_b);
        logic [7:0] x;
        x = base_b ^ cur_b;
        step_n = 0;
        if (x == 8'h00) begin
            run_len = run_len + 9'd1;
            if (32'(run_len) >= RUN_CHUNK)
                put_run();
        end else begin
            if (run_len != 0)
                put_run();
            put_encoded(x);
        end
        if (last_b) begin
            if (run_len != 0)
                put_run();
            if (step_n > 0)
                step_words[step_n-1].frame_end = 1'b1;
            run_len = '0;
            frame_bytes = '0;
        end
        if (step_n > 0)
            step_words[step_n-1].item_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            encoded_q = {encoded_q, step_words[i]};
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            run_len = '0;
            frame_bytes = '0;
            encoded_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (encoded_q.size() == 0) begin
                    $error("unexpected word: tdata %08h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    exp_w = encoded_q.pop_front();
                    if (m_tdata[7:0] !== exp_w.out_byte) begin
                        $error("out_byte expected %02h actual %02h",
                               exp_w.out_byte, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[8] !== exp_w.item_last) begin
                        $error("item_last expected %b actual %b", exp_w.item_last, m_tdata[8]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_w.frame_end) begin
                        $error("frame_end expected %b actual %b", exp_w.frame_end, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[25:9] !== exp_w.enc_count) begin
                        $error("encoded_count expected %0d actual %0d",
                               exp_w.enc_count, m_tdata[25:9]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_pair(s_tdata[7:0], s_tdata[15:8], s_tlast);
        end
        pending_count = encoded_q.size();
    end

endmodule

// File: verif/xor_zero_run_delta_encoder_tb.sv
// Testbench top for xor_zero_run_delta_encoder: reset, clock, stimulus and verdict.
// Depends on xzrd_pkg, the encoder RTL and xzrd_stream_checker.
module xor_zero_run_delta_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;  // [7:0] base_byte, [15:8] cur_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;              // [7:0] out_byte, [8] item_last, [25:9] encoded_count
    logic        m_tlast;

    int fail_count;
    int pending_count;

    int snd_idle_pct = 33;
    int rcv_idle_pct = 62;
    int hold_req     = 0;
    int hold_seen    = 0;
    int items_sent   = 0;
    int phase_end;

    logic [7:0] fr_base[$];
    logic [7:0] fr_cur[$];
    logic       fr_last[$];

    always #5 aclk = ~aclk;

    xor_zero_run_delta_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    xzrd_stream_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] base_b, input logic [7:0] cur_b,
                             input logic last_b);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {cur_b, base_b};
        s_tlast  <= last_b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic add_pair(input logic [7:0] base_b, input logic [7:0] cur_b,
                            input logic last_b);
        fr_base.insert(fr_base.size(), base_b);
        fr_cur.insert(fr_cur.size(), cur_b);
        fr_last.insert(fr_last.size(), last_b);
    endtask

    task automatic add_literals(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            add_pair(b, b ^ 8'($urandom_range(255, 1)), 1'b0);
        end
    endtask

    task automatic add_zeros(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            add_pair(b, b, 1'b0);
        end
    endtask

    task automatic send_queued();
        for (int i = 0; i < fr_base.size(); i++)
            send_word(fr_base[i], fr_cur[i], fr_last[i]);
        fr_base.delete();
        fr_cur.delete();
        fr_last.delete();
    endtask

    task automatic send_random_frame();
        int segs;
        int kind;
        logic [7:0] b;
        segs = $urandom_range(6, 1);
        repeat (segs) begin
            kind = $urandom_range(19);
            if (kind < 8)
                add_literals($urandom_range(8, 1));
            else if (kind < 14)
                add_zeros($urandom_range(12, 1));
            else if (kind < 16)
                add_zeros($urandom_range(40, 13));
            else
                // noise, with early frame ends
                repeat ($urandom_range(6, 1))
                    add_pair(8'($urandom), 8'($urandom), $urandom_range(7) == 0);
        end
        case ($urandom_range(2))
            0: begin
                b = 8'($urandom);
                add_pair(b, b ^ 8'($urandom_range(255, 1)), 1'b1);
            end
            1: begin
                b = 8'($urandom);
                add_pair(b, b, 1'b1);
            end
            default: add_pair(8'($urandom), 8'($urandom), 1'b1);
        endcase
        send_queued();
    endtask

    // receiver: random ready, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (300)
                    @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        #20ms;
        $display("xor_zero_run_delta_encoder_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (8)
            @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: literal extremes, short runs, frame ends in every position
        send_word(8'h00, 8'h00, 1'b0);
        send_word(8'hFF, 8'hFF, 1'b0);
        send_word(8'h00, 8'hFF, 1'b0);
        send_word(8'hFF, 8'h00, 1'b0);
        send_word(8'h01, 8'h00, 1'b0);
        send_word(8'h80, 8'h00, 1'b0);
        send_word(8'hAA, 8'h55, 1'b1);
        send_word(8'h12, 8'h12, 1'b1);
        send_word(8'h5A, 8'h5A, 1'b0);
        send_word(8'hC3, 8'hC3, 1'b0);
        send_word(8'h0F, 8'hF0, 1'b1);
        send_word(8'h00, 8'h01, 1'b0);
        send_word(8'h33, 8'h33, 1'b1);
        send_word(8'h7E, 8'h81, 1'b1);

        // full run mid-frame, literal after it, one-zero run at frame end
        add_zeros(256);
        add_pair(8'h00, 8'h7E, 1'b0);
        add_pair(8'h99, 8'h99, 1'b1);
        send_queued();

        // receiver holds off while the sender keeps pushing
        hold_req++;
        phase_end = items_sent + 10;
        while (items_sent < phase_end)
            send_random_frame();

        phase_end = items_sent + 15;
        while (items_sent < phase_end)
            send_random_frame();

        snd_idle_pct = 62;
        rcv_idle_pct = 33;
        phase_end = items_sent + 15;
        while (items_sent < phase_end)
            send_random_frame();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        phase_end = items_sent + 15;
        while (items_sent < phase_end)
            send_random_frame();

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0)
            @(negedge aclk);
        repeat (20)
            @(negedge aclk);
        if (fail_count == 0)
            $display("xor_zero_run_delta_encoder_tb: PASS");
        else
            $display("xor_zero_run_delta_encoder_tb: FAIL");
        $finish;
    end

endmodule

// File: xor_zero_run_delta_encoder.f
hdl/xzrd_pkg.sv
hdl/xzrd_plan.sv
hdl/xor_zero_run_delta_encoder.sv
verif/xzrd_stream_checker.sv
verif/xor_zero_run_delta_encoder_tb.sv
